@@ hw/rtl/kary_tree_index_router_defines.svh @@
// ----------------------------------------------------------------------------
// kary_tree_index_router_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef KARY_TREE_INDEX_ROUTER_DEFINES_SVH
`define KARY_TREE_INDEX_ROUTER_DEFINES_SVH

// same-cycle implication
`define KTI_ASSERT_SAME(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("kti same-cycle check failed");

// next-cycle implication
`define KTI_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("kti next-cycle check failed");

`endif

@@ hw/rtl/kti_pkg.sv @@
// ----------------------------------------------------------------------------
// kti_pkg
// shared constants and codes for the k-ary tree index router
// ----------------------------------------------------------------------------
package kti_pkg;
  localparam int INDEX_WIDTH_DEF = 32;
  localparam int MAX_ARITY_DEF   = 255;
  localparam int ARITY_W         = 8;
  localparam int FIELD_W         = 32;
  localparam int MODE_W          = 3;
  localparam int SLOT_W          = 8;
  localparam int CFG_IDX_W       = 1;

  localparam logic [MODE_W-1:0] MODE_PARENT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CHILD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEVEL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UP     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ARITY      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  localparam logic [ARITY_W-1:0] ARITY_RESET = 8'd2;
endpackage

@@ hw/rtl/kti_div.sv @@
// ----------------------------------------------------------------------------
// kti_div
// restoring divider, one quotient bit per cycle, divisor up to arity width
// ----------------------------------------------------------------------------
module kti_div
  import kti_pkg::*;
#(
  parameter int IW = INDEX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [IW-1:0]      dividend,
  input  logic [ARITY_W-1:0] divisor,
  output logic               done,
  output logic [IW-1:0]      quotient
);
  localparam int CW = $clog2(IW + 1);

  logic [ARITY_W-1:0] rem_r;
  logic [ARITY_W-1:0] dvs_r;
  logic [IW-1:0]      quo_r;
  logic [CW-1:0]      cnt_r;
  logic               run_r;
  logic               done_r;
  logic [ARITY_W:0]   trial;
  logic               fit;

  assign trial = {rem_r, quo_r[IW-1]};
  assign fit   = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        quo_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fit ? ARITY_W'(trial - {1'b0, dvs_r}) : trial[ARITY_W-1:0];
        quo_r <= {quo_r[IW-2:0], fit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(IW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

@@ hw/rtl/kary_tree_index_router.sv @@
// ----------------------------------------------------------------------------
// kary_tree_index_router
// index queries on an implicit breadth-first k-ary tree: parent, child,
// level, descendant count and next hop up or down
// ----------------------------------------------------------------------------
// channel   ports                                          handshake
// in        in_mode in_node in_other_node in_child_slot    start & !busy
// out       out_value out_found                            out_valid strobe
// cfg       cfg_index cfg_wdata                            cfg_we
//
// one item at a time; busy stays high until its result strobe
// parent takes one division, child a multiply-add and a compare, count two
// multiply-adds per tree level; level and routes take one division per level
// walked, up to 32 levels, on the shared one-bit-per-cycle divider
// synchronous active-low reset; arity 2, node_count 0 after reset
// the result receiver cannot stall
module kary_tree_index_router
  import kti_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
  parameter int MAX_ARITY   = MAX_ARITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [FIELD_W-1:0]   in_node,
  input  logic [FIELD_W-1:0]   in_other_node,
  input  logic [SLOT_W-1:0]    in_child_slot,
  output logic                 out_valid,
  output logic [FIELD_W-1:0]   out_value,
  output logic                 out_found,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata
);
  localparam int IW = INDEX_WIDTH;
  localparam int PW = IW + ARITY_W + 1;
  localparam int CW = $clog2(IW + 1);
  localparam logic [ARITY_W-1:0] KMAX = ARITY_W'(MAX_ARITY);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_DIV, ST_CHILD, ST_CHILD_CMP, ST_CLO, ST_CHI, ST_CACC
  } state_t;

  state_t             state_r;
  logic [ARITY_W-1:0] arity_r;
  logic [IW-1:0]      size_r;
  logic [MODE_W-1:0]  mode_r;
  logic [IW-1:0]      node_r;
  logic [IW-1:0]      other_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [ARITY_W-1:0] k_r;
  logic [IW-1:0]      cur_r;
  logic [IW-1:0]      res_r;
  logic [CW-1:0]      cnt_r;
  logic [PW-1:0]      lo_r;
  logic [PW-1:0]      hi_r;
  logic [PW-1:0]      prod_r;
  logic [IW-1:0]      sum_r;
  logic               div_go_r;
  logic [IW-1:0]      div_arg_r;
  logic               out_valid_r;
  logic [IW-1:0]      out_value_r;
  logic               out_found_r;

  logic               div_done;
  logic [IW-1:0]      div_q;
  logic [PW-1:0]      mul_b;
  logic [PW-1:0]      mul_c;
  logic [PW-1:0]      mul_out;
  logic [PW-1:0]      size_m1;
  logic [PW-1:0]      hi_cl;

  kti_div #(.IW(IW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_arg_r),
    .divisor  (k_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared multiply-add unit
  always_comb begin
    case (state_r)
      ST_CHILD: begin
        mul_b = PW'(node_r);
        mul_c = PW'(slot_r) + PW'(1);
      end
      ST_CHI: begin
        mul_b = hi_r;
        mul_c = PW'(k_r);
      end
      default: begin
        mul_b = lo_r;
        mul_c = PW'(1);
      end
    endcase
  end

  assign mul_out = PW'(PW'(k_r) * mul_b) + mul_c;
  assign size_m1 = PW'(size_r) - PW'(1);
  assign hi_cl   = (prod_r > size_m1) ? size_m1 : prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      arity_r     <= ARITY_RESET;
      size_r      <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ARITY:      arity_r <= cfg_wdata[ARITY_W-1:0];
          CFG_NODE_COUNT: size_r  <= cfg_wdata[IW-1:0];
          default:        ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            mode_r  <= in_mode;
            node_r  <= in_node[IW-1:0];
            other_r <= in_other_node[IW-1:0];
            slot_r  <= in_child_slot;
            k_r     <= (arity_r > KMAX) ? KMAX : arity_r;
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          cnt_r <= '0;
          case (mode_r)
            MODE_PARENT: begin
              if (k_r == '0 || node_r == '0) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else begin
                div_go_r <= 1'b1; div_arg_r <= node_r - 1'b1; state_r <= ST_DIV;
              end
            end
            MODE_CHILD: begin
              if (k_r == '0 || ARITY_W'(slot_r) >= k_r) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_CHILD;
              end
            end
            MODE_LEVEL: begin
              if (k_r == '0 || node_r == '0) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b1; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else if (k_r == ARITY_W'(1)) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b1; out_value_r <= node_r;
                state_r <= ST_IDLE;
              end else begin
                div_go_r <= 1'b1; div_arg_r <= node_r - 1'b1; state_r <= ST_DIV;
              end
            end
            MODE_COUNT: begin
              if (k_r == '0 || node_r >= size_r) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b1; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else if (k_r == ARITY_W'(1)) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b1;
                out_value_r <= size_r - 1'b1 - node_r;
                state_r <= ST_IDLE;
              end else begin
                lo_r <= PW'(node_r); hi_r <= PW'(node_r); sum_r <= '0;
                state_r <= ST_CLO;
              end
            end
            MODE_UP: begin
              if (k_r == '0 || node_r == other_r || node_r >= size_r ||
                  other_r >= size_r || node_r == '0) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else begin
                div_go_r <= 1'b1; div_arg_r <= node_r - 1'b1; state_r <= ST_DIV;
              end
            end
            MODE_DOWN: begin
              if (k_r == '0 || node_r == other_r || node_r >= size_r ||
                  other_r >= size_r) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else if (k_r == ARITY_W'(1)) begin
                out_valid_r <= 1'b1;
                out_found_r <= other_r > node_r;
                out_value_r <= (other_r > node_r) ? node_r + 1'b1 : '0;
                state_r <= ST_IDLE;
              end else if (other_r == '0) begin
                out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                state_r <= ST_IDLE;
              end else begin
                cur_r <= other_r;
                div_go_r <= 1'b1; div_arg_r <= other_r - 1'b1; state_r <= ST_DIV;
              end
            end
            default: begin
              out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
              state_r <= ST_IDLE;
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            cnt_r <= cnt_r + 1'b1;
            case (mode_r)
              MODE_PARENT: begin
                out_valid_r <= 1'b1; out_found_r <= 1'b1; out_value_r <= div_q;
                state_r <= ST_IDLE;
              end
              MODE_LEVEL: begin
                if (div_q == '0) begin
                  out_valid_r <= 1'b1; out_found_r <= 1'b1;
                  out_value_r <= IW'(cnt_r) + 1'b1;
                  state_r <= ST_IDLE;
                end else begin
                  div_go_r <= 1'b1; div_arg_r <= div_q - 1'b1;
                end
              end
              MODE_UP: begin
                if (cnt_r == '0) begin
                  res_r <= div_q;
                end
                if (k_r == ARITY_W'(1)) begin
                  out_valid_r <= 1'b1;
                  out_found_r <= other_r < node_r;
                  out_value_r <= (other_r < node_r) ? div_q : '0;
                  state_r <= ST_IDLE;
                end else if (div_q == other_r) begin
                  out_valid_r <= 1'b1; out_found_r <= 1'b1;
                  out_value_r <= (cnt_r == '0) ? div_q : res_r;
                  state_r <= ST_IDLE;
                end else if (div_q == '0) begin
                  out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                  state_r <= ST_IDLE;
                end else begin
                  div_go_r <= 1'b1; div_arg_r <= div_q - 1'b1;
                end
              end
              default: begin
                if (div_q == node_r) begin
                  out_valid_r <= 1'b1; out_found_r <= 1'b1; out_value_r <= cur_r;
                  state_r <= ST_IDLE;
                end else if (div_q == '0) begin
                  out_valid_r <= 1'b1; out_found_r <= 1'b0; out_value_r <= '0;
                  state_r <= ST_IDLE;
                end else begin
                  cur_r <= div_q;
                  div_go_r <= 1'b1; div_arg_r <= div_q - 1'b1;
                end
              end
            endcase
          end
        end
        ST_CHILD: begin
          prod_r  <= mul_out;
          state_r <= ST_CHILD_CMP;
        end
        ST_CHILD_CMP: begin
          out_valid_r <= 1'b1;
          out_found_r <= prod_r < PW'(size_r);
          out_value_r <= (prod_r < PW'(size_r)) ? prod_r[IW-1:0] : '0;
          state_r     <= ST_IDLE;
        end
        ST_CLO: begin
          prod_r  <= mul_out;
          state_r <= ST_CHI;
        end
        ST_CHI: begin
          lo_r    <= prod_r;
          prod_r  <= mul_out;
          state_r <= ST_CACC;
        end
        ST_CACC: begin
          if (lo_r >= PW'(size_r)) begin
            out_valid_r <= 1'b1; out_found_r <= 1'b1; out_value_r <= sum_r;
            state_r <= ST_IDLE;
          end else begin
            hi_r    <= hi_cl;
            sum_r   <= sum_r + IW'(hi_cl - lo_r) + 1'b1;
            state_r <= ST_CLO;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_value = FIELD_W'(out_value_r);
  assign out_found = out_found_r;
endmodule

@@ hw/rtl/kti_checker.sv @@
// ----------------------------------------------------------------------------
// kti_checker
// port-level checks on the router's command and result beats
// ----------------------------------------------------------------------------
`include "kary_tree_index_router_defines.svh"

module kti_checker
  import kti_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [FIELD_W-1:0] out_value,
  input logic               out_found
);
  `KTI_ASSERT_SAME(a_none_zero, clk, rst_n, out_valid && !out_found, out_value == '0)
  `KTI_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `KTI_ASSERT_NEXT(a_one_beat, clk, rst_n, out_valid, !out_valid)
  `KTI_ASSERT_SAME(a_beat_after_busy, clk, rst_n, out_valid, $past(busy))
endmodule

bind kary_tree_index_router kti_checker u_kti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_value (out_value),
  .out_found (out_found)
);
